>>> design/sbto_pkg.sv
package sbto_pkg;

    // Row geometry
    localparam int ROW_BYTES  = 16;
    localparam int REF_BYTES  = 18;
    localparam int NUM_SHIFTS = 3;

    // Widths: one row SAD is at most 16 * 255 = 4080
    localparam int ROWSAD_W  = 12;
    localparam int SUM_W     = 16;
    localparam int ROW_CNT_W = 4;

    // Depth of the row queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef logic [ROWSAD_W-1:0] row_sad_t;
    typedef logic [SUM_W-1:0]    sum_t;

    // One queued row: per-shift row SADs and the block-end mark
    typedef struct packed {
        logic                          last;
        row_sad_t [NUM_SHIFTS-1:0]     sad;
    } row_entry_t;

    localparam int ENTRY_W = $bits(row_entry_t);

endpackage

>>> design/sbto_front.sv
module sbto_front #(
    parameter int BLOCK_ROWS  = 16,
    parameter int NUM_OFFSETS = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [63:0]           src_bytes_low,
    input  logic [63:0]           src_bytes_high,
    input  logic [63:0]           ref_bytes_low,
    input  logic [63:0]           ref_bytes_high,
    input  logic [15:0]           ref_bytes_extra,
    input  logic                  q_full,
    output logic                  q_wr,
    output sbto_pkg::row_entry_t  q_entry
);

    localparam logic [sbto_pkg::ROW_CNT_W-1:0] LAST_ROW =
        sbto_pkg::ROW_CNT_W'(BLOCK_ROWS - 1);

    logic [sbto_pkg::ROW_CNT_W-1:0] row_cnt_reg;
    logic [sbto_pkg::ROW_CNT_W-1:0] row_cnt_next;
    logic                           accept;
    logic                           last_row;

    logic [sbto_pkg::ROW_BYTES*8-1:0] src_vec;
    logic [sbto_pkg::REF_BYTES*8-1:0] ref_vec;

    assign src_vec = {src_bytes_high, src_bytes_low};
    assign ref_vec = {ref_bytes_extra, ref_bytes_high, ref_bytes_low};

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign last_row = (row_cnt_reg == LAST_ROW);

    // Row counter: marks the last row of each block
    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (last_row)
                row_cnt_next = '0;
            else
                row_cnt_next = row_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_cnt_reg <= '0;
        else
            row_cnt_reg <= row_cnt_next;
    end

    // Row SAD per shift: abs differences, then a four-level adder tree
    for (genvar k = 0; k < sbto_pkg::NUM_SHIFTS; k++)
    begin : g_shift
        if (k < NUM_OFFSETS)
        begin : g_on
            logic [7:0]  diff [16];
            logic [8:0]  lvl1 [8];
            logic [9:0]  lvl2 [4];
            logic [10:0] lvl3 [2];

            always_comb
            begin
                logic [7:0] a;
                logic [7:0] b;
                for (int i = 0; i < 16; i++)
                begin
                    a = src_vec[i*8 +: 8];
                    b = ref_vec[(i+k)*8 +: 8];
                    diff[i] = (a > b) ? (a - b) : (b - a);
                end
                for (int i = 0; i < 8; i++)
                    lvl1[i] = {1'b0, diff[2*i]} + {1'b0, diff[2*i+1]};
                for (int i = 0; i < 4; i++)
                    lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
                for (int i = 0; i < 2; i++)
                    lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
            end

            assign q_entry.sad[k] = {1'b0, lvl3[0]} + {1'b0, lvl3[1]};
        end
        else
        begin : g_off
            assign q_entry.sad[k] = '0;
        end
    end

    assign q_entry.last = last_row;
    assign q_wr         = accept;

endmodule

>>> design/sbto_queue.sv
module sbto_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  sbto_pkg::row_entry_t  wr_data,
    output logic                  full,
    input  logic                  rd_en,
    output sbto_pkg::row_entry_t  rd_data,
    output logic                  empty
);

    localparam int DEPTH = sbto_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    sbto_pkg::row_entry_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("row queue fill count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("row queue count did not grow on write");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_rd && !do_wr) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("row queue count did not shrink on read");

endmodule

>>> design/sbto_back.sv
module sbto_back (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     q_empty,
    input  sbto_pkg::row_entry_t                     q_entry,
    output logic                                     q_rd,
    output logic                                     res_valid,
    input  logic                                     res_pop,
    output sbto_pkg::sum_t [sbto_pkg::NUM_SHIFTS-1:0] res_sad
);

    sbto_pkg::sum_t [sbto_pkg::NUM_SHIFTS-1:0] sum_reg;
    sbto_pkg::sum_t [sbto_pkg::NUM_SHIFTS-1:0] sum_next;
    sbto_pkg::sum_t [sbto_pkg::NUM_SHIFTS-1:0] total;
    sbto_pkg::sum_t [sbto_pkg::NUM_SHIFTS-1:0] res_sad_reg;
    sbto_pkg::sum_t [sbto_pkg::NUM_SHIFTS-1:0] res_sad_next;
    logic                                      res_valid_reg;
    logic                                      res_valid_next;
    logic                                      out_free;

    // A block-end row needs the result register; other rows never wait
    assign out_free = !res_valid_reg || res_pop;
    assign q_rd     = !q_empty && (!q_entry.last || out_free);

    // Saturating accumulate of the row SADs
    always_comb
    begin
        logic [sbto_pkg::SUM_W:0] wide;
        for (int k = 0; k < sbto_pkg::NUM_SHIFTS; k++)
        begin
            wide = {1'b0, sum_reg[k]} + (sbto_pkg::SUM_W + 1)'(q_entry.sad[k]);
            total[k] = wide[sbto_pkg::SUM_W] ? '1 : wide[sbto_pkg::SUM_W-1:0];
        end
    end

    always_comb
    begin
        sum_next       = sum_reg;
        res_sad_next   = res_sad_reg;
        res_valid_next = res_valid_reg && !res_pop;
        if (q_rd)
        begin
            if (q_entry.last)
            begin
                res_sad_next   = total;
                res_valid_next = 1'b1;
                sum_next       = '0;
            end
            else
            begin
                sum_next = total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_sad_reg <= res_sad_next;
    end

    assign res_valid = res_valid_reg;
    assign res_sad   = res_sad_reg;

endmodule

>>> design/sad_block_three_offsets_unit.sv
// Block SAD of a 16-wide source block against a reference at shifts of 0, 1 and 2 bytes.
// Push one row per beat (16 source bytes, 18 reference bytes); after the BLOCK_ROWS-th
// row one result beat carries the three block SADs (offsets at or above NUM_OFFSETS read
// 0) and the sums restart. A row is taken every cycle while full is low: the front
// stage forms the three row SADs with an adder tree straight into a four-entry row
// queue, and the back stage folds one queued row per cycle into the running sums but
// holds a block-end row while a result waits unpopped. A result is registered when its
// last row leaves the queue; full rises only if results left unpopped let the queue fill.
module sad_block_three_offsets_unit #(
    parameter int BLOCK_ROWS  = 16,
    parameter int NUM_OFFSETS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] src_bytes_low,
    input  logic [63:0] src_bytes_high,
    input  logic [63:0] ref_bytes_low,
    input  logic [63:0] ref_bytes_high,
    input  logic [15:0] ref_bytes_extra,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] sad_offset_zero,
    output logic [15:0] sad_offset_one,
    output logic [15:0] sad_offset_two
);

    logic                 q_full;
    logic                 q_wr;
    sbto_pkg::row_entry_t q_wr_entry;
    logic                 q_empty;
    logic                 q_rd;
    sbto_pkg::row_entry_t q_rd_entry;
    logic                 res_valid;

    sbto_pkg::sum_t [sbto_pkg::NUM_SHIFTS-1:0] res_sad;

    // Front: accept rows, compute row SADs, mark block end
    sbto_front #(
        .BLOCK_ROWS  (BLOCK_ROWS),
        .NUM_OFFSETS (NUM_OFFSETS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .src_bytes_low   (src_bytes_low),
        .src_bytes_high  (src_bytes_high),
        .ref_bytes_low   (ref_bytes_low),
        .ref_bytes_high  (ref_bytes_high),
        .ref_bytes_extra (ref_bytes_extra),
        .q_full          (q_full),
        .q_wr            (q_wr),
        .q_entry         (q_wr_entry)
    );

    // Row queue between front and back
    sbto_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_entry),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_entry),
        .empty   (q_empty)
    );

    // Back: accumulate and hold the block result
    sbto_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (q_rd_entry),
        .q_rd      (q_rd),
        .res_valid (res_valid),
        .res_pop   (pop),
        .res_sad   (res_sad)
    );

    assign empty           = !res_valid;
    assign sad_offset_zero = res_sad[0];
    assign sad_offset_one  = res_sad[1];
    assign sad_offset_two  = res_sad[2];

endmodule
